// File: hdl/cdc_pkg.sv
// shared types, field widths and codes for the connection direction classifier
package cdc_pkg;

  localparam int ID_W       = 64;
  localparam int BYTES_W    = 32;
  localparam int SUM_W      = 40;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 32;
  localparam int THR_W      = 24;
  localparam int SKEW_W     = 8;
  localparam int IVL_W      = 16;
  localparam int SCALED_W   = SUM_W + SKEW_W;
  localparam int DIV_STEP_W = $clog2(TIME_W);
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic REQ_NOTE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_SKEW      = 2'd2;
  localparam logic [1:0] REG_INTERVAL  = 2'd3;

  localparam logic [THR_W-1:0]  THR_RESET  = 24'd20480;
  localparam logic [SKEW_W-1:0] SKEW_RESET = 8'd10;
  localparam logic [IVL_W-1:0]  IVL_RESET  = 16'd10;

  localparam logic [1:0] CLS_BELOW   = 2'd0;
  localparam logic [1:0] CLS_READ    = 2'd1;
  localparam logic [1:0] CLS_WRITTEN = 2'd2;
  localparam logic [1:0] CLS_BOTH    = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic [ID_W-1:0]    conn_id;
    logic [BYTES_W-1:0] bytes_read;
    logic [BYTES_W-1:0] bytes_written;
    logic [TIME_W-1:0]  time_seconds;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] below_count;
    logic [CNT_W-1:0] mostly_read_count;
    logic [CNT_W-1:0] mostly_written_count;
    logic [CNT_W-1:0] both_count;
    logic             interval_closed;
    logic             table_full;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [SUM_W-1:0] rsum;
    logic [SUM_W-1:0] wsum;
  } entry_t;

  typedef struct packed {
    logic               classify;
    logic               match;
    logic               place;
    logic [ID_W-1:0]    key;
    logic [BYTES_W-1:0] rd;
    logic [BYTES_W-1:0] wr;
  } proc_ctrl_t;

  typedef struct packed {
    logic       cls_valid;
    logic [1:0] cls;
    logic       hit;
    logic       placed;
  } proc_stat_t;

endpackage

// File: hdl/cdc_cell.sv
// one table cell: holds a connection entry and hands it to its neighbor on each shift
module cdc_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_i,
  input  logic            clear_i,
  input  cdc_pkg::entry_t entry_i,
  output cdc_pkg::entry_t entry_o
);

  logic                      valid_r;
  logic [cdc_pkg::ID_W-1:0]  id_r;
  logic [cdc_pkg::SUM_W-1:0] rsum_r;
  logic [cdc_pkg::SUM_W-1:0] wsum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clear_i) begin
      valid_r <= 1'b0;
    end else if (shift_i) begin
      valid_r <= entry_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_i) begin
      id_r   <= entry_i.id;
      rsum_r <= entry_i.rsum;
      wsum_r <= entry_i.wsum;
    end
  end

  assign entry_o.valid = valid_r;
  assign entry_o.id    = id_r;
  assign entry_o.rsum  = rsum_r;
  assign entry_o.wsum  = wsum_r;

endmodule

// File: hdl/cdc_proc.sv
// head of the cell ring: classifies, updates or claims the entry passing by
module cdc_proc (
  input  cdc_pkg::entry_t              head_i,
  input  cdc_pkg::proc_ctrl_t          ctrl_i,
  input  logic [cdc_pkg::THR_W-1:0]    thr_i,
  input  logic [cdc_pkg::SKEW_W-1:0]   skew_i,
  output cdc_pkg::entry_t              entry_o,
  output cdc_pkg::proc_stat_t          stat_o
);

  logic [cdc_pkg::SUM_W:0]      total;
  logic [cdc_pkg::SCALED_W-1:0] r_scaled;
  logic [cdc_pkg::SCALED_W-1:0] w_scaled;
  logic [cdc_pkg::SUM_W:0]      r_add;
  logic [cdc_pkg::SUM_W:0]      w_add;
  logic [1:0]                   cls;
  cdc_pkg::entry_t              after_cls;
  logic                         hit;
  logic                         placed;

  always_comb begin
    total    = {1'b0, head_i.rsum} + {1'b0, head_i.wsum};
    r_scaled = cdc_pkg::SCALED_W'(head_i.rsum) * cdc_pkg::SCALED_W'(skew_i);
    w_scaled = cdc_pkg::SCALED_W'(head_i.wsum) * cdc_pkg::SCALED_W'(skew_i);
    if (total < (cdc_pkg::SUM_W + 1)'(thr_i)) begin
      cls = cdc_pkg::CLS_BELOW;
    end else if (cdc_pkg::SCALED_W'(head_i.rsum) >= w_scaled) begin
      cls = cdc_pkg::CLS_READ;
    end else if (cdc_pkg::SCALED_W'(head_i.wsum) >= r_scaled) begin
      cls = cdc_pkg::CLS_WRITTEN;
    end else begin
      cls = cdc_pkg::CLS_BOTH;
    end

    // closing an interval empties the entry before any lookup sees it
    after_cls = head_i;
    if (ctrl_i.classify) begin
      after_cls.valid = 1'b0;
    end

    hit    = ctrl_i.match && after_cls.valid && (after_cls.id == ctrl_i.key);
    placed = ctrl_i.place && !after_cls.valid;

    r_add = {1'b0, after_cls.rsum} + (cdc_pkg::SUM_W + 1)'(ctrl_i.rd);
    w_add = {1'b0, after_cls.wsum} + (cdc_pkg::SUM_W + 1)'(ctrl_i.wr);

    entry_o = after_cls;
    if (hit) begin
      entry_o.rsum = r_add[cdc_pkg::SUM_W] ? '1 : r_add[cdc_pkg::SUM_W-1:0];
      entry_o.wsum = w_add[cdc_pkg::SUM_W] ? '1 : w_add[cdc_pkg::SUM_W-1:0];
    end else if (placed) begin
      entry_o.valid = 1'b1;
      entry_o.id    = ctrl_i.key;
      entry_o.rsum  = cdc_pkg::SUM_W'(ctrl_i.rd);
      entry_o.wsum  = cdc_pkg::SUM_W'(ctrl_i.wr);
    end

    stat_o.cls_valid = ctrl_i.classify && head_i.valid;
    stat_o.cls       = cls;
    stat_o.hit       = hit;
    stat_o.placed    = placed;
  end

endmodule

// File: hdl/cdc_div.sv
// remainder of the time past the boundary over the interval, one quotient bit per cycle
module cdc_div (
  input  logic                         clk,
  input  logic                         load_i,
  input  logic [cdc_pkg::TIME_W-1:0]   dividend_i,
  input  logic [cdc_pkg::IVL_W-1:0]    divisor_i,
  output logic [cdc_pkg::IVL_W-1:0]    rem_nxt_o,
  output logic                         last_o
);

  logic [cdc_pkg::TIME_W-1:0]     dvd_r;
  logic [cdc_pkg::TIME_W-1:0]     dvd_nxt;
  logic [cdc_pkg::IVL_W-1:0]      rem_r;
  logic [cdc_pkg::IVL_W-1:0]      rem_nxt;
  logic [cdc_pkg::DIV_STEP_W-1:0] step_r;
  logic [cdc_pkg::DIV_STEP_W-1:0] step_nxt;
  logic [cdc_pkg::IVL_W:0]        rem_sh;

  always_comb begin
    rem_sh = {rem_r, dvd_r[cdc_pkg::TIME_W-1]};
    if (rem_sh >= {1'b0, divisor_i}) begin
      rem_nxt = cdc_pkg::IVL_W'(rem_sh - {1'b0, divisor_i});
    end else begin
      rem_nxt = rem_sh[cdc_pkg::IVL_W-1:0];
    end
    dvd_nxt  = {dvd_r[cdc_pkg::TIME_W-2:0], 1'b0};
    step_nxt = step_r + 1'b1;
    if (load_i) begin
      dvd_nxt  = dividend_i;
      rem_nxt  = '0;
      step_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  assign rem_nxt_o = rem_nxt;
  assign last_o    = (step_r == cdc_pkg::DIV_STEP_W'(cdc_pkg::TIME_W - 1));

endmodule

// File: hdl/connection_direction_classifier.sv
// top level of the connection direction classifier: control, counters and the cell ring
//
// Input transactions (in_valid/in_stall) carry a note or a clear request; every
// accepted transaction gives exactly one result transaction (out_valid/out_stall)
// holding the four class counters and the interval_closed/table_full flags.
// Connection entries live in a ring of TABLE_DEPTH cells that, during a scan or placing
// pass, rotates one step per cycle past a single head unit, which classifies, updates
// or claims entries. One item is worked on at a time; in_stall is high while it is in
// progress. Clear requests, disabled notes and zero-byte notes that close nothing go
// from idle straight to the result. A note with bytes makes a full ring rotation to
// look up its id and, for a new id, a placing pass unless the table is full; closing
// an interval first runs the bit-serial remainder unit ahead of the ring rotation.
// The result sits in an output register, so a stalled receiver holds one result while
// the next item is already accepted and processed; that item then waits. Synchronous
// reset empties the table at once, zeroes the counters and the interval boundary
// and loads the register defaults; no clearing pass is needed. Configuration is
// written over the cfg_ port by the user only while idle; not enforced by the block.
module connection_direction_classifier #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cdc_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cdc_pkg::out_item_t               out_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [cdc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [cdc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [cdc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  localparam int CW = $clog2(TABLE_DEPTH);
  localparam int OW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_PLACE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic                         en_r, en_nxt;
  logic [cdc_pkg::THR_W-1:0]    thr_r, thr_nxt;
  logic [cdc_pkg::SKEW_W-1:0]   skew_r, skew_nxt;
  logic [cdc_pkg::IVL_W-1:0]    ivl_r, ivl_nxt;
  logic [cdc_pkg::TIME_W-1:0]   nb_r, nb_nxt;
  logic                         bset_r, bset_nxt;
  logic [cdc_pkg::CNT_W-1:0]    below_r, below_nxt;
  logic [cdc_pkg::CNT_W-1:0]    read_r, read_nxt;
  logic [cdc_pkg::CNT_W-1:0]    written_r, written_nxt;
  logic [cdc_pkg::CNT_W-1:0]    both_r, both_nxt;
  logic                         closed_r, closed_nxt;
  logic                         full_r, full_nxt;
  logic                         upd_r, upd_nxt;
  logic                         hit_r, hit_nxt;
  logic [OW-1:0]                occ_r, occ_nxt;
  logic [CW-1:0]                step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  cdc_pkg::out_item_t           out_data_r;
  logic [cdc_pkg::ID_W-1:0]     key_r;
  logic [cdc_pkg::BYTES_W-1:0]  rd_r;
  logic [cdc_pkg::BYTES_W-1:0]  wr_r;
  logic [cdc_pkg::TIME_W-1:0]   when_r;

  logic                         in_acc;
  logic                         cfg_wr;
  logic [1:0]                   cfg_idx;
  logic [cdc_pkg::IVL_W-1:0]    ivl_eff;
  logic [cdc_pkg::TIME_W:0]     first_sum;
  logic [cdc_pkg::TIME_W-1:0]   nb_eff;
  logic [cdc_pkg::TIME_W:0]     adv_sum;
  logic [OW-1:0]                occ_eff;
  logic                         hit_any;
  logic                         out_load;
  logic                         shift;
  logic                         cell_clear;
  logic                         div_load;
  logic [cdc_pkg::IVL_W-1:0]    rem_nxt;
  logic                         div_last;

  cdc_pkg::entry_t              chain [TABLE_DEPTH];
  cdc_pkg::entry_t              proc_out;
  cdc_pkg::proc_ctrl_t          ctrl;
  cdc_pkg::proc_stat_t          stat;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx  = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;
  assign ivl_eff  = (ivl_r == '0) ? cdc_pkg::IVL_W'(1) : ivl_r;
  assign shift    = (state_r == ST_SCAN) || (state_r == ST_PLACE);
  assign cell_clear = in_acc && (in_data.req_type == cdc_pkg::REQ_CLEAR);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    case (cfg_idx)
      cdc_pkg::REG_ENABLE:    cfg_prdata = cdc_pkg::CFG_DATA_W'(en_r);
      cdc_pkg::REG_THRESHOLD: cfg_prdata = cdc_pkg::CFG_DATA_W'(thr_r);
      cdc_pkg::REG_SKEW:      cfg_prdata = cdc_pkg::CFG_DATA_W'(skew_r);
      cdc_pkg::REG_INTERVAL:  cfg_prdata = cdc_pkg::CFG_DATA_W'(ivl_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // first note opens the interval at its own time plus one interval
  assign first_sum = {1'b0, in_data.time_seconds} + cdc_pkg::TIME_W'(ivl_eff);
  assign nb_eff    = bset_r ? nb_r : (first_sum[cdc_pkg::TIME_W] ? '1 :
                                      first_sum[cdc_pkg::TIME_W-1:0]);
  // next boundary is the note time plus what is left of the current interval
  assign adv_sum   = {1'b0, when_r} + cdc_pkg::TIME_W'(ivl_eff - rem_nxt);

  assign div_load  = in_acc;

  cdc_div u_div (
    .clk        (clk),
    .load_i     (div_load),
    .dividend_i (in_data.time_seconds - nb_eff),
    .divisor_i  (ivl_eff),
    .rem_nxt_o  (rem_nxt),
    .last_o     (div_last)
  );

  always_comb begin
    ctrl.classify = (state_r == ST_SCAN) && closed_r;
    ctrl.match    = (state_r == ST_SCAN) && upd_r && !hit_r;
    ctrl.place    = (state_r == ST_PLACE);
    ctrl.key      = key_r;
    ctrl.rd       = rd_r;
    ctrl.wr       = wr_r;
  end

  cdc_proc u_proc (
    .head_i  (chain[TABLE_DEPTH-1]),
    .ctrl_i  (ctrl),
    .thr_i   (thr_r),
    .skew_i  (skew_r),
    .entry_o (proc_out),
    .stat_o  (stat)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      cdc_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift_i (shift),
        .clear_i (cell_clear),
        .entry_i (proc_out),
        .entry_o (chain[i])
      );
    end else begin : g_rest
      cdc_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift_i (shift),
        .clear_i (cell_clear),
        .entry_i (chain[i-1]),
        .entry_o (chain[i])
      );
    end
  end

  assign hit_any = hit_r || stat.hit;
  assign occ_eff = closed_r ? '0 : occ_r;

  always_comb begin
    state_nxt   = state_r;
    en_nxt      = en_r;
    thr_nxt     = thr_r;
    skew_nxt    = skew_r;
    ivl_nxt     = ivl_r;
    nb_nxt      = nb_r;
    bset_nxt    = bset_r;
    below_nxt   = below_r;
    read_nxt    = read_r;
    written_nxt = written_r;
    both_nxt    = both_r;
    closed_nxt  = closed_r;
    full_nxt    = full_r;
    upd_nxt     = upd_r;
    hit_nxt     = hit_r;
    occ_nxt     = occ_r;
    step_nxt    = step_r;
    out_valid_nxt = out_valid_r;

    if (cfg_wr) begin
      case (cfg_idx)
        cdc_pkg::REG_ENABLE:    en_nxt   = cfg_pwdata[0];
        cdc_pkg::REG_THRESHOLD: thr_nxt  = cfg_pwdata[cdc_pkg::THR_W-1:0];
        cdc_pkg::REG_SKEW:      skew_nxt = cfg_pwdata[cdc_pkg::SKEW_W-1:0];
        cdc_pkg::REG_INTERVAL:  ivl_nxt  = cfg_pwdata[cdc_pkg::IVL_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (stat.cls_valid) begin
      case (stat.cls)
        cdc_pkg::CLS_BELOW:   below_nxt   = below_r + 1'b1;
        cdc_pkg::CLS_READ:    read_nxt    = read_r + 1'b1;
        cdc_pkg::CLS_WRITTEN: written_nxt = written_r + 1'b1;
        cdc_pkg::CLS_BOTH:    both_nxt    = both_r + 1'b1;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          closed_nxt = 1'b0;
          full_nxt   = 1'b0;
          hit_nxt    = 1'b0;
          step_nxt   = '0;
          upd_nxt    = (in_data.bytes_read != '0) || (in_data.bytes_written != '0);
          state_nxt  = ST_DONE;
          if (in_data.req_type == cdc_pkg::REQ_CLEAR) begin
            below_nxt   = '0;
            read_nxt    = '0;
            written_nxt = '0;
            both_nxt    = '0;
            occ_nxt     = '0;
          end else if (en_r) begin
            nb_nxt   = nb_eff;
            bset_nxt = 1'b1;
            if (in_data.time_seconds >= nb_eff) begin
              closed_nxt = 1'b1;
              state_nxt  = ST_DIV;
            end else if (upd_nxt) begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_last) begin
          nb_nxt    = adv_sum[cdc_pkg::TIME_W] ? '1 : adv_sum[cdc_pkg::TIME_W-1:0];
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        hit_nxt  = hit_any;
        step_nxt = step_r + 1'b1;
        if (step_r == CW'(TABLE_DEPTH - 1)) begin
          occ_nxt = occ_eff;
          if (!upd_r || hit_any) begin
            state_nxt = ST_DONE;
          end else if (occ_eff == OW'(TABLE_DEPTH)) begin
            full_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_PLACE;
          end
        end
      end
      ST_PLACE: begin
        if (stat.placed) begin
          occ_nxt   = occ_r + 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      en_r        <= 1'b0;
      thr_r       <= cdc_pkg::THR_RESET;
      skew_r      <= cdc_pkg::SKEW_RESET;
      ivl_r       <= cdc_pkg::IVL_RESET;
      nb_r        <= '0;
      bset_r      <= 1'b0;
      below_r     <= '0;
      read_r      <= '0;
      written_r   <= '0;
      both_r      <= '0;
      closed_r    <= 1'b0;
      full_r      <= 1'b0;
      upd_r       <= 1'b0;
      hit_r       <= 1'b0;
      occ_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      thr_r       <= thr_nxt;
      skew_r      <= skew_nxt;
      ivl_r       <= ivl_nxt;
      nb_r        <= nb_nxt;
      bset_r      <= bset_nxt;
      below_r     <= below_nxt;
      read_r      <= read_nxt;
      written_r   <= written_nxt;
      both_r      <= both_nxt;
      closed_r    <= closed_nxt;
      full_r      <= full_nxt;
      upd_r       <= upd_nxt;
      hit_r       <= hit_nxt;
      occ_r       <= occ_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r  <= in_data.conn_id;
      rd_r   <= in_data.bytes_read;
      wr_r   <= in_data.bytes_written;
      when_r <= in_data.time_seconds;
    end
    if (out_load) begin
      out_data_r.below_count          <= below_r;
      out_data_r.mostly_read_count    <= read_r;
      out_data_r.mostly_written_count <= written_r;
      out_data_r.both_count           <= both_r;
      out_data_r.interval_closed      <= closed_r;
      out_data_r.table_full           <= full_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(TABLE_DEPTH))
    else $error("table occupancy above depth");

  a_close_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.interval_closed && out_data.table_full))
    else $error("closed interval reported a full table");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.req_type == cdc_pkg::REQ_CLEAR) |=>
      (occ_r == '0 && below_r == '0 && both_r == '0))
    else $error("clear transaction left table or counters");
`endif

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the connection direction classifier
module tb;

  localparam int DEPTH     = 64;
  localparam int LIMIT     = 3_000_000;
  localparam int QUIET_LO  = 700;
  localparam int QUIET_HI  = 1000;
  localparam int HOLD_AT   = 150;
  localparam int HOLD_LEN  = 400;
  localparam int TAIL      = 300;
  localparam bit [63:0] SUM_TOP  = 64'hFF_FFFF_FFFF;
  localparam bit [63:0] TIME_TOP = 64'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cdc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cdc_pkg::out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [cdc_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [cdc_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [cdc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  connection_direction_classifier #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies
  bit                       on_copy   = 1'b0;
  bit [cdc_pkg::THR_W-1:0]  thr_copy  = cdc_pkg::THR_RESET;
  bit [cdc_pkg::SKEW_W-1:0] skew_copy = cdc_pkg::SKEW_RESET;
  bit [cdc_pkg::IVL_W-1:0]  ivl_copy  = cdc_pkg::IVL_RESET;

  // connection table and interval state as the block should hold them
  bit [DEPTH-1:0]            slot_used = '0;
  bit [cdc_pkg::ID_W-1:0]    slot_key [DEPTH];
  bit [cdc_pkg::SUM_W-1:0]   slot_rd  [DEPTH];
  bit [cdc_pkg::SUM_W-1:0]   slot_wr  [DEPTH];
  bit [cdc_pkg::TIME_W-1:0]  cut_time  = '0;
  bit                        cut_armed = 1'b0;
  bit [cdc_pkg::CNT_W-1:0]   n_below = '0, n_read = '0, n_written = '0, n_both = '0;

  cdc_pkg::in_item_t  feed_q[$];
  cdc_pkg::out_item_t due_q[$];
  cdc_pkg::out_item_t want;
  bit [cdc_pkg::ID_W-1:0] ids [128];
  bit [cdc_pkg::TIME_W-1:0] clock_s;

  int queued_n = 0, accepted_n = 0, checked_n = 0, errors = 0;
  int closed_n = 0, dropped_n = 0, settings_n = 0, cycles = 0;
  int hold_left = 0;
  bit held = 1'b0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    errors++;
    if (errors <= 40)
      $display("mismatch after %0d results: %s got %0h, want %0h", checked_n, what, got, exp_v);
  endtask

  function automatic bit quiet();
    return accepted_n >= QUIET_LO && accepted_n < QUIET_HI;
  endfunction

  function automatic bit [cdc_pkg::SUM_W-1:0] sat40(bit [cdc_pkg::SUM_W-1:0] a,
                                                    bit [cdc_pkg::BYTES_W-1:0] b);
    bit [63:0] s;
    s = 64'(a) + 64'(b);
    return (s > SUM_TOP) ? SUM_TOP[cdc_pkg::SUM_W-1:0] : s[cdc_pkg::SUM_W-1:0];
  endfunction

  // expected result of one transaction, advancing the table and counters
  function automatic cdc_pkg::out_item_t tally_item(cdc_pkg::in_item_t t);
    cdc_pkg::out_item_t res;
    bit [63:0] ivl, k, b, r, w;
    int hit, free_at;
    res = '0;
    ivl = (ivl_copy == 0) ? 64'd1 : 64'(ivl_copy);
    if (t.req_type == cdc_pkg::REQ_CLEAR) begin
      n_below = '0;
      n_read = '0;
      n_written = '0;
      n_both = '0;
      slot_used = '0;
    end else if (on_copy) begin
      if (!cut_armed) begin
        b = 64'(t.time_seconds) + ivl;
        cut_time = (b > TIME_TOP) ? TIME_TOP[31:0] : b[31:0];
        cut_armed = 1'b1;
      end
      if (t.time_seconds >= cut_time) begin
        k = (64'(t.time_seconds) - 64'(cut_time)) / ivl + 1;
        b = 64'(cut_time) + k * ivl;
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_used[i]) begin
            r = 64'(slot_rd[i]);
            w = 64'(slot_wr[i]);
            if (r + w < 64'(thr_copy)) n_below++;
            else if (r >= w * 64'(skew_copy)) n_read++;
            else if (w >= r * 64'(skew_copy)) n_written++;
            else n_both++;
          end
        end
        slot_used = '0;
        cut_time = (b > TIME_TOP) ? TIME_TOP[31:0] : b[31:0];
        res.interval_closed = 1'b1;
        closed_n++;
      end
      if (t.bytes_read != 0 || t.bytes_written != 0) begin
        hit = -1;
        free_at = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_used[i]) begin
            if (hit < 0 && slot_key[i] == t.conn_id) hit = i;
          end else if (free_at < 0) begin
            free_at = i;
          end
        end
        if (hit >= 0) begin
          slot_rd[hit] = sat40(slot_rd[hit], t.bytes_read);
          slot_wr[hit] = sat40(slot_wr[hit], t.bytes_written);
        end else if (free_at >= 0) begin
          slot_used[free_at] = 1'b1;
          slot_key[free_at] = t.conn_id;
          slot_rd[free_at] = cdc_pkg::SUM_W'(t.bytes_read);
          slot_wr[free_at] = cdc_pkg::SUM_W'(t.bytes_written);
        end else begin
          res.table_full = 1'b1;
          dropped_n++;
        end
      end
    end
    res.below_count = n_below;
    res.mostly_read_count = n_read;
    res.mostly_written_count = n_written;
    res.both_count = n_both;
    return res;
  endfunction

  // driver: offers queued transactions, predicts each one as it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_q.push_back(tally_item(in_data));
        accepted_n++;
      end
      if (!in_valid || !in_stall) begin
        if (feed_q.size() > 0 && (quiet() || $urandom_range(0, 99) >= 20)) begin
          in_valid <= 1'b1;
          in_data <= feed_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results in order and drives the receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          report_mismatch("result with nothing due, below_count", out_data.below_count, 0);
        end else begin
          want = due_q.pop_front();
          if (out_data.below_count !== want.below_count)
            report_mismatch("below_count", out_data.below_count, want.below_count);
          if (out_data.mostly_read_count !== want.mostly_read_count)
            report_mismatch("mostly_read_count", out_data.mostly_read_count,
                            want.mostly_read_count);
          if (out_data.mostly_written_count !== want.mostly_written_count)
            report_mismatch("mostly_written_count", out_data.mostly_written_count,
                            want.mostly_written_count);
          if (out_data.both_count !== want.both_count)
            report_mismatch("both_count", out_data.both_count, want.both_count);
          if (out_data.interval_closed !== want.interval_closed)
            report_mismatch("interval_closed", 32'(out_data.interval_closed),
                            32'(want.interval_closed));
          if (out_data.table_full !== want.table_full)
            report_mismatch("table_full", 32'(out_data.table_full), 32'(want.table_full));
        end
        checked_n++;
      end
      // one long hold-off so the block backs up onto its input
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && checked_n >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet() && ($urandom_range(0, 99) < 20);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, due_q.size());
      $display("tb failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] mask;
    case (idx)
      cdc_pkg::REG_ENABLE:    mask = 32'h1;
      cdc_pkg::REG_THRESHOLD: mask = 32'hFF_FFFF;
      cdc_pkg::REG_SKEW:      mask = 32'hFF;
      default:                mask = 32'hFFFF;
    endcase
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= (val & mask) | ($urandom & ~mask);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      cdc_pkg::REG_ENABLE:    on_copy = val[0];
      cdc_pkg::REG_THRESHOLD: thr_copy = val[cdc_pkg::THR_W-1:0];
      cdc_pkg::REG_SKEW:      skew_copy = val[cdc_pkg::SKEW_W-1:0];
      default:                ivl_copy = val[cdc_pkg::IVL_W-1:0];
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== (val & mask))
      report_mismatch("register readback", cfg_prdata, val & mask);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_regs(bit en, bit [cdc_pkg::THR_W-1:0] thr, bit [cdc_pkg::SKEW_W-1:0] sk,
                          bit [cdc_pkg::IVL_W-1:0] iv);
    write_reg(cdc_pkg::REG_THRESHOLD, 32'(thr));
    write_reg(cdc_pkg::REG_SKEW, 32'(sk));
    write_reg(cdc_pkg::REG_INTERVAL, 32'(iv));
    write_reg(cdc_pkg::REG_ENABLE, 32'(en));
    settings_n++;
  endtask

  task automatic push_note(bit [63:0] id, bit [31:0] rd, bit [31:0] wr, bit [31:0] tm);
    cdc_pkg::in_item_t it;
    it.req_type = cdc_pkg::REQ_NOTE;
    it.conn_id = id;
    it.bytes_read = rd;
    it.bytes_written = wr;
    it.time_seconds = tm;
    feed_q.push_back(it);
    queued_n++;
  endtask

  task automatic push_clear();
    cdc_pkg::in_item_t it;
    it.req_type = cdc_pkg::REQ_CLEAR;
    it.conn_id = {$urandom, $urandom};
    it.bytes_read = $urandom;
    it.bytes_written = $urandom;
    it.time_seconds = clock_s;
    feed_q.push_back(it);
    queued_n++;
  endtask

  task automatic advance(bit [31:0] stride);
    clock_s = (clock_s > 32'hFFFF_FFFF - stride) ? 32'hFFFF_FFFF : clock_s + stride;
  endtask

  // wait until every transaction is taken and answered, then let the block settle
  task automatic drain();
    do @(posedge clk); while (accepted_n != queued_n || checked_n != accepted_n);
    repeat (4) @(posedge clk);
  endtask

  // mostly connections from a pool with rising time, plus clears, zero-byte notes,
  // interval jumps and unrelated noise; heavy bursts send only large pool notes
  task automatic make_burst(int n, int pool_n, int stride_max, int jump_pct, bit heavy);
    int roll;
    bit [63:0] id;
    bit [31:0] rd, wr, ivl;
    ivl = (ivl_copy == 0) ? 32'd1 : 32'(ivl_copy);
    for (int i = 0; i < n; i++) begin
      roll = heavy ? 50 : $urandom_range(0, 99);
      id = ids[$urandom_range(0, pool_n - 1)];
      case ($urandom_range(0, 3))
        0: begin
          rd = $urandom_range(0, 4000);
          wr = $urandom_range(0, 4000);
        end
        1: begin
          rd = $urandom_range(1 << 20, 32'hFFFF_FFFF);
          wr = $urandom_range(0, 4096);
        end
        2: begin
          rd = $urandom_range(0, 4096);
          wr = $urandom_range(1 << 20, 32'hFFFF_FFFF);
        end
        default: begin
          rd = $urandom_range(1 << 16, 1 << 22);
          wr = $urandom_range(1 << 16, 1 << 22);
        end
      endcase
      if (heavy) begin
        rd = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
        wr = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
      end
      if (roll < 3) begin
        push_clear();
      end else if (roll < 11) begin
        push_note({$urandom, $urandom}, $urandom, $urandom, clock_s - $urandom_range(0, 5));
      end else begin
        if (roll < 19) begin
          rd = 0;
          wr = 0;
        end else if (roll < 19 + jump_pct) begin
          advance(ivl * $urandom_range(1, 3));
        end
        advance($urandom_range(0, stride_max));
        push_note(id, rd, wr, clock_s);
      end
    end
  endtask

  initial begin
    ids[0] = '0;
    ids[1] = '1;
    for (int i = 2; i < 128; i++) ids[i] = {$urandom, $urandom};
    clock_s = 32'd200000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // collection still off after reset: note ignored, clear still acts
    push_note(ids[9], 100, 100, 50);
    push_clear();
    drain();

    set_regs(1'b1, 24'd20480, 8'd10, 16'd10);
    push_note(ids[1], 32'hFFFF_FFFF, 0, 100);
    push_note(ids[0], 0, 32'hFFFF_FFFF, 101);
    push_note(64'hA5A5_5A5A_0F0F_F0F0, 50000, 40000, 102);
    push_note(64'h5A5A_A5A5_F0F0_0F0F, 10, 10, 103);
    push_note(ids[0], 0, 0, 105);
    push_note(ids[0], 7, 9, 106);
    push_note(ids[2], 0, 0, 110);        // zero-byte note closes the interval
    push_note(ids[3], 100, 100, 135);    // boundary skips whole intervals
    push_clear();
    push_note(ids[3], 1, 1, 136);
    drain();

    // zero threshold, zero skew, zero interval
    set_regs(1'b1, 24'd0, 8'd0, 16'd0);
    push_note(ids[4], 5, 500, 137);
    push_note(ids[5], 0, 0, 140);
    push_note(ids[5], 3, 3, 141);
    push_note(ids[6], 9, 0, 142);
    drain();

    set_regs(1'b1, 24'hFF_FFFF, 8'd255, 16'hFFFF);
    push_note(ids[7], 32'hFFFF_FFFF, 32'hFFFF_FFFF, 143);
    push_note(ids[7], 32'hFFFF_FFFF, 1, 144);
    push_note(ids[8], 0, 0, 143 + 65535);
    drain();

    set_regs(1'b1, 24'd20480, 8'd10, 16'd10);
    make_burst(300, 40, 2, 2, 1'b0);
    drain();

    // long interval and a wide pool so the table fills and drops ids
    set_regs(1'b1, 24'hFF_FFFF, 8'd255, 16'hFFFF);
    make_burst(250, 128, 2, 0, 1'b0);
    drain();

    set_regs(1'b0, 24'($urandom), 8'($urandom), 16'($urandom));
    make_burst(60, 40, 2, 2, 1'b0);
    drain();

    set_regs(1'b1, 24'($urandom_range(0, 1 << 20)), 8'($urandom_range(1, 16)),
             16'($urandom_range(2, 40)));
    make_burst(400, 70, 2, 2, 1'b0);
    drain();

    set_regs(1'b1, 24'd0, 8'd1, 16'd1);
    make_burst(200, 10, 1, 2, 1'b0);
    drain();

    // one connection hammered until both sums saturate, then closed out
    set_regs(1'b1, 24'd20480, 8'd10, 16'hFFFF);
    make_burst(280, 1, 0, 0, 1'b1);
    advance(32'd65535);
    push_note(ids[1], 1, 1, clock_s);
    drain();

    set_regs(1'b1, 24'($urandom_range(0, 1 << 20)), 8'($urandom_range(1, 255)),
             16'($urandom_range(1, 40)));
    make_burst(400, 70, 2, 2, 1'b0);
    drain();

    // times at the top of the range so the boundary saturates
    set_regs(1'b1, 24'd20480, 8'd10, 16'hFFFF);
    clock_s = 32'hFFFF_FF00;
    make_burst(60, 20, 8, 2, 1'b0);
    drain();

    repeat (TAIL) @(posedge clk);
    if (due_q.size() != 0)
      report_mismatch("results never produced", 0, due_q.size());
    $display("run covered %0d transactions under %0d register settings", accepted_n,
             settings_n);
    $display("%0d interval closes, %0d dropped ids, %0d mismatches", closed_n, dropped_n,
             errors);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/cdc_pkg.sv
hdl/cdc_cell.sv
hdl/cdc_proc.sv
hdl/cdc_div.sv
hdl/connection_direction_classifier.sv
tb/sv/tb.sv
